[design/rrsd_pkg.sv]
// ----------------------------------------------------------------------------
// rrsd_pkg
// Shared types and constants of the row run-length sprite decoder.
// ----------------------------------------------------------------------------
package rrsd_pkg;

  localparam int MAX_FRAME_SIDE = 2048;
  localparam int SIDE_W         = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int ROW_W          = 16;
  localparam int COL_W          = 12;
  localparam int RUN_W          = 7;
  localparam int SPAN_POS_W     = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_ROW_LIMIT    = 2'd2
  } cfg_reg_t;

  localparam logic [COL_W-1:0] COL_MAX       = 12'd4095;
  localparam logic [COL_W-1:0] SIDE_RESET    = 12'd64;
  localparam logic [ROW_W-1:0] LIMIT_RESET   = 16'd64;
  localparam logic             KIND_START    = 1'b0;
  localparam logic [7:0]       KEY_NEXT_ROW  = 8'd0;
  localparam logic [7:0]       KEY_SKIP      = 8'd1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [SPAN_POS_W-1:0] row;
    logic [SPAN_POS_W-1:0] col;
    logic [RUN_W-1:0]      length;
    logic [7:0]            color;
  } span_t;

endpackage

[design/rrsd_in_reg.sv]
// ----------------------------------------------------------------------------
// rrsd_in_reg
// Input register: holds one accepted item until the decode stage takes it.
// ----------------------------------------------------------------------------
module rrsd_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rrsd_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_valid,
  output rrsd_pkg::item_t item
);

  logic            valid_r;
  logic            valid_nxt;
  rrsd_pkg::item_t item_r;
  logic            load;

  assign in_ready   = !valid_r || advance;
  assign load       = in_valid && in_ready;
  assign valid_nxt  = load ? 1'b1 : (advance ? 1'b0 : valid_r);
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

endmodule

[design/rrsd_core.sv]
// ----------------------------------------------------------------------------
// rrsd_core
// Stream parser state, frame configuration and span clipping.
// ----------------------------------------------------------------------------
module rrsd_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rrsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrsd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                item_valid,
  input  rrsd_pkg::item_t                     item,
  input  logic                                out_free,
  output logic                                advance,
  output logic                                span_valid,
  output rrsd_pkg::span_t                     span
);

  typedef enum logic [1:0] {
    MODE_KEY  = 2'd0,
    MODE_SKIP = 2'd1,
    MODE_LIT  = 2'd2,
    MODE_FILL = 2'd3
  } mode_t;

  mode_t                          parse_mode_r, parse_mode_nxt;
  logic [rrsd_pkg::ROW_W-1:0]     row_count_r, row_count_nxt;
  logic [rrsd_pkg::COL_W-1:0]     col_count_r, col_count_nxt;
  logic [rrsd_pkg::RUN_W-1:0]     run_remaining_r, run_remaining_nxt;
  logic [rrsd_pkg::COL_W-1:0]     frame_width_r;
  logic [rrsd_pkg::COL_W-1:0]     frame_height_r;
  logic [rrsd_pkg::ROW_W-1:0]     row_limit_r;

  logic [rrsd_pkg::SIDE_W-1:0]    fw_eff;
  logic [rrsd_pkg::SIDE_W-1:0]    fh_eff;
  logic [rrsd_pkg::SIDE_W-1:0]    room;
  logic [rrsd_pkg::SIDE_W-1:0]    col_sum;
  logic [7:0]                     col_inc;
  logic [rrsd_pkg::RUN_W-1:0]     emit_len;
  logic [rrsd_pkg::RUN_W-1:0]     clip_len;
  logic                           emit_req;
  logic                           emit_ok;
  logic [7:0]                     b;

  assign b = item.data_byte;

  assign fw_eff = ({1'b0, frame_width_r} > rrsd_pkg::SIDE_W'(rrsd_pkg::MAX_FRAME_SIDE)) ?
                  rrsd_pkg::SIDE_W'(rrsd_pkg::MAX_FRAME_SIDE) : {1'b0, frame_width_r};
  assign fh_eff = ({1'b0, frame_height_r} > rrsd_pkg::SIDE_W'(rrsd_pkg::MAX_FRAME_SIDE)) ?
                  rrsd_pkg::SIDE_W'(rrsd_pkg::MAX_FRAME_SIDE) : {1'b0, frame_height_r};

  assign room     = fw_eff - {1'b0, col_count_r};
  assign emit_len = (parse_mode_r == MODE_LIT) ? rrsd_pkg::RUN_W'(1) : run_remaining_r;
  assign clip_len = ({6'd0, emit_len} > room) ? room[rrsd_pkg::RUN_W-1:0] : emit_len;
  assign emit_ok  = (row_count_r < {3'd0, fh_eff}) && ({1'b0, col_count_r} < fw_eff) &&
                    (emit_len != '0);

  always_comb begin
    col_inc = 8'd0;
    case (parse_mode_r)
      MODE_SKIP: col_inc = b;
      MODE_LIT:  col_inc = 8'd1;
      MODE_FILL: col_inc = {1'b0, run_remaining_r};
      default:   col_inc = 8'd0;
    endcase
  end

  assign col_sum = {1'b0, col_count_r} + {5'd0, col_inc};

  always_comb begin
    parse_mode_nxt    = parse_mode_r;
    row_count_nxt     = row_count_r;
    col_count_nxt     = col_count_r;
    run_remaining_nxt = run_remaining_r;
    emit_req          = 1'b0;
    if (item.kind == rrsd_pkg::KIND_START) begin
      parse_mode_nxt    = MODE_KEY;
      row_count_nxt     = '0;
      col_count_nxt     = '0;
      run_remaining_nxt = '0;
    end else if (row_count_r < row_limit_r) begin
      case (parse_mode_r)
        MODE_KEY: begin
          if (b == rrsd_pkg::KEY_NEXT_ROW) begin
            row_count_nxt = row_count_r + rrsd_pkg::ROW_W'(1);
            col_count_nxt = '0;
          end else if (b == rrsd_pkg::KEY_SKIP) begin
            parse_mode_nxt = MODE_SKIP;
          end else if (b[7:1] != '0) begin
            run_remaining_nxt = b[7:1];
            parse_mode_nxt    = b[0] ? MODE_LIT : MODE_FILL;
          end
        end
        MODE_SKIP: begin
          col_count_nxt  = col_sum[rrsd_pkg::COL_W] ? rrsd_pkg::COL_MAX :
                           col_sum[rrsd_pkg::COL_W-1:0];
          parse_mode_nxt = MODE_KEY;
        end
        MODE_LIT: begin
          emit_req          = emit_ok;
          col_count_nxt     = col_sum[rrsd_pkg::COL_W] ? rrsd_pkg::COL_MAX :
                              col_sum[rrsd_pkg::COL_W-1:0];
          run_remaining_nxt = run_remaining_r - rrsd_pkg::RUN_W'(1);
          if (run_remaining_nxt == '0) begin
            parse_mode_nxt = MODE_KEY;
          end
        end
        default: begin
          emit_req          = emit_ok;
          col_count_nxt     = col_sum[rrsd_pkg::COL_W] ? rrsd_pkg::COL_MAX :
                              col_sum[rrsd_pkg::COL_W-1:0];
          run_remaining_nxt = '0;
          parse_mode_nxt    = MODE_KEY;
        end
      endcase
    end
  end

  assign advance     = item_valid && (!emit_req || out_free);
  assign span_valid  = advance && emit_req;
  assign span.row    = row_count_r[rrsd_pkg::SPAN_POS_W-1:0];
  assign span.col    = col_count_r[rrsd_pkg::SPAN_POS_W-1:0];
  assign span.length = clip_len;
  assign span.color  = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_mode_r    <= MODE_KEY;
      row_count_r     <= '0;
      col_count_r     <= '0;
      run_remaining_r <= '0;
      frame_width_r   <= rrsd_pkg::SIDE_RESET;
      frame_height_r  <= rrsd_pkg::SIDE_RESET;
      row_limit_r     <= rrsd_pkg::LIMIT_RESET;
    end else begin
      if (advance) begin
        parse_mode_r    <= parse_mode_nxt;
        row_count_r     <= row_count_nxt;
        col_count_r     <= col_count_nxt;
        run_remaining_r <= run_remaining_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          rrsd_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[rrsd_pkg::COL_W-1:0];
          rrsd_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[rrsd_pkg::COL_W-1:0];
          rrsd_pkg::REG_ROW_LIMIT:    row_limit_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

[design/rrsd_out_reg.sv]
// ----------------------------------------------------------------------------
// rrsd_out_reg
// Result register: holds one span until the downstream side takes it.
// ----------------------------------------------------------------------------
module rrsd_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            span_valid,
  input  rrsd_pkg::span_t span,
  output logic            out_free,
  output logic            out_valid,
  input  logic            out_ready,
  output rrsd_pkg::span_t out_span
);

  logic            valid_r;
  logic            valid_nxt;
  rrsd_pkg::span_t span_r;

  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = span_valid ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  assign out_valid = valid_r;
  assign out_span  = span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (span_valid) begin
      span_r <= span;
    end
  end

endmodule

[design/row_rle_sprite_decoder.sv]
// ----------------------------------------------------------------------------
// row_rle_sprite_decoder
// Row-based run-length sprite decoder producing clipped pixel spans.
// ----------------------------------------------------------------------------
// A span reaches out_valid via the input register, decode stage and result register.
// Throughput: one byte per cycle; the decode stage stalls only while a
// result is pending and the result register is full and not being drained.
// Reset: synchronous, active low; clears parser state and valid flags and
// loads 64 into frame_width, frame_height and row_limit.
module row_rle_sprite_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rrsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrsd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [7:0]                        in_data_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rrsd_pkg::SPAN_POS_W-1:0]   out_span_row,
  output logic [rrsd_pkg::SPAN_POS_W-1:0]   out_span_col,
  output logic [rrsd_pkg::RUN_W-1:0]        out_span_length,
  output logic [7:0]                        out_span_color
);

  rrsd_pkg::item_t in_item;
  rrsd_pkg::item_t item;
  rrsd_pkg::span_t span;
  rrsd_pkg::span_t out_span;
  logic            item_valid;
  logic            advance;
  logic            span_valid;
  logic            out_free;

  assign in_item.kind      = in_kind;
  assign in_item.data_byte = in_data_byte;

  rrsd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  rrsd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .advance    (advance),
    .span_valid (span_valid),
    .span       (span)
  );

  rrsd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .span_valid (span_valid),
    .span       (span),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_span   (out_span)
  );

  assign out_span_row    = out_span.row;
  assign out_span_col    = out_span.col;
  assign out_span_length = out_span.length;
  assign out_span_color  = out_span.color;

endmodule

[design/rrsd_checker.sv]
// ----------------------------------------------------------------------------
// rrsd_checker
// Port-level checks of the sprite decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rrsd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [rrsd_pkg::SPAN_POS_W-1:0] out_span_row,
  input logic [rrsd_pkg::SPAN_POS_W-1:0] out_span_col,
  input logic [rrsd_pkg::RUN_W-1:0]      out_span_length,
  input logic [7:0]                      out_span_color
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_span_row) &&
    $stable(out_span_col) && $stable(out_span_length) && $stable(out_span_color))
    else $error("result changed while stalled");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_span_length != '0)
    else $error("empty span transferred");

  a_span_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({2'b00, out_span_col} + {5'd0, out_span_length}) <=
    13'(rrsd_pkg::MAX_FRAME_SIDE))
    else $error("span runs past the widest frame");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind row_rle_sprite_decoder rrsd_checker u_rrsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_span_row    (out_span_row),
  .out_span_col    (out_span_col),
  .out_span_length (out_span_length),
  .out_span_color  (out_span_color)
);
